// File: rtl/ctf_pkg.sv
// Shared types, constants and register codes for the four-channel compare timer.
`default_nettype none

package ctf_pkg;

  // Block sizing.
  localparam int CHANNELS   = 4;
  localparam int COUNT_BITS = 32;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths of the item ports.
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int SEL_W    = 4;
  localparam int STATUS_W = 2;
  localparam int FLAGS_W  = 4;
  localparam int VEC_W    = 10;

  // Divider sizing: divisor is prescaler times divide value.
  localparam int PRESCALE_W = 8;
  localparam int DIVIDE_W   = 6;
  localparam int DIVISOR_W  = PRESCALE_W + DIVIDE_W;
  localparam int STEP_W     = $clog2(DATA_W);

  // Register masks, reset values and the vector base.
  localparam logic [DATA_W-1:0] CTRL_WMASK = 32'h0000_ff03;
  localparam logic [DATA_W-1:0] DIV_WMASK  = 32'h803f_0000;
  localparam logic [DATA_W-1:0] DIV_RESET  = 32'h8000_0000;
  localparam logic [VEC_W-1:0]  VEC_BASE   = 10'd36;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 3'd0,
    OP_ADVANCE = 3'd1,
    OP_DBG_ON  = 3'd2,
    OP_DBG_OFF = 3'd3,
    OP_POR     = 3'd4
  } op_t;

  // Register selects.
  localparam logic [SEL_W-1:0] REG_CTRL  = 4'd0;
  localparam logic [SEL_W-1:0] REG_COUNT = 4'd1;
  localparam logic [SEL_W-1:0] REG_EN0   = 4'd2;
  localparam logic [SEL_W-1:0] REG_EN3   = 4'd5;
  localparam logic [SEL_W-1:0] REG_FLAG0 = 4'd6;
  localparam logic [SEL_W-1:0] REG_FLAG3 = 4'd9;
  localparam logic [SEL_W-1:0] REG_CMP0  = 4'd10;
  localparam logic [SEL_W-1:0] REG_CMP3  = 4'd13;
  localparam logic [SEL_W-1:0] REG_ACK   = 4'd14;
  localparam logic [SEL_W-1:0] REG_DIV   = 4'd15;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_UNKNOWN  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ZERO_DIV = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCAN,
    ST_CHECK,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

// File: rtl/ctf_divider.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
`default_nettype none

module ctf_divider (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [ctf_pkg::DATA_W-1:0]    dividend,
  input  wire logic [ctf_pkg::DIVISOR_W-1:0] divisor,
  output logic                               done,
  output logic [ctf_pkg::DATA_W-1:0]         quotient
);
  import ctf_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [DATA_W-1:0]    quo_r, quo_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] div_r, div_nxt;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_r, quo_r[DATA_W-1]};
    diff  = trial - {1'b0, div_r};
    fits  = (trial >= {1'b0, div_r});
  end

  // Step sequencing and datapath update.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(DATA_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DATA_W-2:0], fits};
      rem_nxt = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers reset; datapath registers do not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: rtl/compare_timer_four_channel.sv
// Compare timer: one item at a time under a small sequencer, result in an output register.
// Path from accept to out_valid: a write, mode change or non-counting advance goes straight to RESULT;
// an enable write that turns a channel on passes CHECK first; an advance whose quotient is zero passes
// DIVIDE, and a counting advance passes DIVIDE, then SCAN, where one shared compare unit checks one channel per cycle.
// The next item is accepted in the cycle after its result loads; a stalled result waits there.
// Synchronous active-low reset clears all timer state (divider word to its enable value).
`default_nettype none

module compare_timer_four_channel (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ctf_pkg::OP_W-1:0]     in_op,
  input  wire logic [ctf_pkg::SEL_W-1:0]    in_reg_select,
  input  wire logic [ctf_pkg::DATA_W-1:0]   in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [ctf_pkg::STATUS_W-1:0]      out_status,
  output logic [ctf_pkg::DATA_W-1:0]        out_counter_value,
  output logic [ctf_pkg::FLAGS_W-1:0]       out_channel_flags,
  output logic [ctf_pkg::VEC_W-1:0]         out_irq_vector
);
  import ctf_pkg::*;

  // Sequencer and timer state.
  state_t                 state_r, state_nxt;
  logic [15:0]            ctrl_r, ctrl_nxt;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0]  old_r, old_nxt;
  logic [CHANNELS-1:0]    en_r, en_nxt;
  logic [CHANNELS-1:0]    flag_r, flag_nxt;
  logic [COUNT_BITS-1:0]  cmp_r [CHANNELS];
  logic                   cmp_we;
  logic [CH_W-1:0]        cmp_wsel;
  logic [COUNT_BITS-1:0]  cmp_wdata;
  logic [VEC_W-1:0]       ack_r, ack_nxt;
  logic [DATA_W-1:0]      divw_r, divw_nxt;
  logic                   dbg_r, dbg_nxt;
  logic [STATUS_W-1:0]    stat_r, stat_nxt;
  logic [CH_W-1:0]        ch_r, ch_nxt;

  // Result register.
  logic                   ovalid_r, ovalid_nxt;
  logic [STATUS_W-1:0]    ostat_r, ostat_nxt;
  logic [DATA_W-1:0]      ocnt_r, ocnt_nxt;
  logic [FLAGS_W-1:0]     oflags_r, oflags_nxt;
  logic [VEC_W-1:0]       ovec_r, ovec_nxt;

  // Decode of the incoming item.
  logic                   accept;
  logic [SEL_W-1:0]       ch_off;
  logic                   ch_ok;
  logic [CH_W-1:0]        ch_idx;
  logic [DIVISOR_W-1:0]   divisor;
  logic                   frozen;
  logic                   stopped;
  logic                   en_fire_chk;

  // Shared compare unit and divider interface.
  logic [COUNT_BITS-1:0]  cmp_sel;
  logic                   in_window;
  logic                   hit;
  logic                   last_ch;
  logic                   result_load;
  logic                   div_start;
  logic                   div_done;
  logic [DATA_W-1:0]      div_quot;
  logic [COUNT_BITS-1:0]  new_cnt;

  assign accept      = in_valid && !in_stall;
  assign in_stall    = (state_r != ST_IDLE);
  assign result_load = (state_r == ST_RESULT) && (!ovalid_r || !out_stall);

  // Register and channel decode.
  always_comb begin
    if ((in_reg_select >= REG_EN0) && (in_reg_select <= REG_EN3)) begin
      ch_off = in_reg_select - REG_EN0;
    end else if ((in_reg_select >= REG_FLAG0) && (in_reg_select <= REG_FLAG3)) begin
      ch_off = in_reg_select - REG_FLAG0;
    end else if ((in_reg_select >= REG_CMP0) && (in_reg_select <= REG_CMP3)) begin
      ch_off = in_reg_select - REG_CMP0;
    end else begin
      ch_off = '0;
    end
    ch_ok   = (32'(ch_off) < CHANNELS);
    ch_idx  = ch_off[CH_W-1:0];
    divisor = DIVISOR_W'(ctrl_r[15:8]) * DIVISOR_W'(divw_r[21:16]);
    frozen  = dbg_r && ctrl_r[1];
    stopped = !divw_r[31] || !ctrl_r[0];
    en_fire_chk = (in_reg_select >= REG_EN0) && (in_reg_select <= REG_EN3) && ch_ok
                  && !en_r[ch_idx] && in_data[0];
  end

  // Shared compare unit: equality for an enable write, wrap-around window for an advance.
  always_comb begin
    cmp_sel = cmp_r[ch_r];
    if (cnt_r > old_r) begin
      in_window = (cmp_sel > old_r) && (cmp_sel < cnt_r);
    end else begin
      in_window = (cmp_sel > old_r) || (cmp_sel < cnt_r);
    end
    if (state_r == ST_CHECK) begin
      hit = (cmp_sel == cnt_r);
    end else begin
      hit = en_r[ch_r] && in_window;
    end
    last_ch = (ch_r == CH_W'(CHANNELS - 1));
    new_cnt = cnt_r + COUNT_BITS'(div_quot);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RESULT;
          if ((op_t'(in_op) == OP_WRITE) && en_fire_chk) begin
            state_nxt = ST_CHECK;
          end else if ((op_t'(in_op) == OP_ADVANCE) && !frozen && !stopped
                       && (divisor != '0)) begin
            state_nxt = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_nxt = (new_cnt == cnt_r) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_ch) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_CHECK:  state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (result_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    ctrl_nxt   = ctrl_r;
    cnt_nxt    = cnt_r;
    old_nxt    = old_r;
    en_nxt     = en_r;
    flag_nxt   = flag_r;
    ack_nxt    = ack_r;
    divw_nxt   = divw_r;
    dbg_nxt    = dbg_r;
    stat_nxt   = stat_r;
    ch_nxt     = ch_r;
    cmp_we     = 1'b0;
    cmp_wsel   = ch_idx;
    cmp_wdata  = COUNT_BITS'(in_data);
    div_start  = 1'b0;
    ovalid_nxt = ovalid_r && out_stall;
    ostat_nxt  = ostat_r;
    ocnt_nxt   = ocnt_r;
    oflags_nxt = oflags_r;
    ovec_nxt   = ovec_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          stat_nxt = STAT_OK;
          case (op_t'(in_op))
            OP_WRITE: begin
              if (in_reg_select == REG_CTRL) begin
                ctrl_nxt = 16'(in_data & CTRL_WMASK);
              end else if (in_reg_select == REG_DIV) begin
                divw_nxt = in_data & DIV_WMASK;
              end else if ((in_reg_select == REG_COUNT) || (in_reg_select == REG_ACK)) begin
                stat_nxt = STAT_OK;
              end else if (!ch_ok) begin
                stat_nxt = STAT_UNKNOWN;
              end else if (in_reg_select <= REG_EN3) begin
                en_nxt[ch_idx] = in_data[0];
                ch_nxt         = ch_idx;
              end else if (in_reg_select <= REG_FLAG3) begin
                if (in_data[0] && flag_r[ch_idx]) begin
                  flag_nxt[ch_idx] = 1'b0;
                  ack_nxt          = '0;
                end
              end else begin
                cmp_we = 1'b1;
              end
            end
            OP_ADVANCE: begin
              if (!frozen && !stopped) begin
                if (divisor == '0) begin
                  stat_nxt = STAT_ZERO_DIV;
                end else begin
                  div_start = 1'b1;
                end
              end
            end
            OP_DBG_ON:  dbg_nxt = 1'b1;
            OP_DBG_OFF: dbg_nxt = 1'b0;
            OP_POR: begin
              ctrl_nxt = '0;
              cnt_nxt  = '0;
              en_nxt   = '0;
              flag_nxt = '0;
              ack_nxt  = '0;
              divw_nxt = DIV_RESET;
              dbg_nxt  = 1'b0;
            end
            default:    stat_nxt = STAT_UNKNOWN;
          endcase
        end
      end
      ST_DIVIDE: begin
        if (div_done && (new_cnt != cnt_r)) begin
          old_nxt = cnt_r;
          cnt_nxt = new_cnt;
          ch_nxt  = '0;
        end
      end
      ST_SCAN, ST_CHECK: begin
        if (hit) begin
          flag_nxt[ch_r] = 1'b1;
          ack_nxt        = VEC_BASE + VEC_W'(ch_r);
        end
        if (state_r == ST_SCAN) begin
          ch_nxt = ch_r + 1'b1;
        end
      end
      ST_RESULT: begin
        if (result_load) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = stat_r;
          ocnt_nxt   = DATA_W'(cnt_r);
          ovec_nxt   = ack_r;
          for (int i = 0; i < FLAGS_W; i++) begin
            oflags_nxt[i] = (i < CHANNELS) ? flag_r[i] : 1'b0;
          end
        end
      end
      default: begin
        ovalid_nxt = ovalid_r && out_stall;
      end
    endcase
  end

  // Timer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ctrl_r   <= '0;
      cnt_r    <= '0;
      en_r     <= '0;
      flag_r   <= '0;
      ack_r    <= '0;
      divw_r   <= DIV_RESET;
      dbg_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ctrl_r   <= ctrl_nxt;
      cnt_r    <= cnt_nxt;
      en_r     <= en_nxt;
      flag_r   <= flag_nxt;
      ack_r    <= ack_nxt;
      divw_r   <= divw_nxt;
      dbg_r    <= dbg_nxt;
      ovalid_r <= ovalid_nxt;
    end
    old_r    <= old_nxt;
    stat_r   <= stat_nxt;
    ch_r     <= ch_nxt;
    ostat_r  <= ostat_nxt;
    ocnt_r   <= ocnt_nxt;
    oflags_r <= oflags_nxt;
    ovec_r   <= ovec_nxt;
  end

  // Compare values; a power-on reset item or the reset pin clears them.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (!rst_n || (accept && (op_t'(in_op) == OP_POR))) begin
        cmp_r[i] <= '0;
      end else if (cmp_we && (cmp_wsel == CH_W'(i))) begin
        cmp_r[i] <= cmp_wdata;
      end
    end
  end

  // Elapsed cycles divided by the combined divisor.
  ctf_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_data),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign out_valid         = ovalid_r;
  assign out_status        = ostat_r;
  assign out_counter_value = ocnt_r;
  assign out_channel_flags = oflags_r;
  assign out_irq_vector    = ovec_r;

endmodule

`default_nettype wire
